@@ hw/rtl/bbpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bbpe_pkg
// Shared types and constants of the bicubic Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbpe_pkg;

    localparam int NUM_POINTS = 16;
    localparam int ADDR_W     = 4;
    localparam int PARAM_W    = 17;   // unsigned Q1.16, up to nearly 2.0
    localparam int FRAC_W     = 16;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_POINT = 2'd1,
        OP_DERIV = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_COEF,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    // evaluation command handed from the front to the back
    typedef struct packed {
        logic               deriv;
        logic [PARAM_W-1:0] u;
        logic [PARAM_W-1:0] v;
    } t_cmd;

    // per-cycle controls from the sequencer to the three coordinate lanes
    typedef struct packed {
        logic       cap;      // shift in one control point from the RAM
        logic       coef;     // form polynomial coefficients
        logic       pass_v;   // second pass: curve over the row values
        logic       deriv;
        logic       mul;      // register the partial products
        logic       add;      // Horner accumulate
        logic       row_wr;   // keep the finished row value
        logic [1:0] row_sel;
    } t_lane_ctl;

endpackage

@@ hw/rtl/bbpe_ram.sv @@
// ----------------------------------------------------------------------------
// bbpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bbpe_front.sv @@
// ----------------------------------------------------------------------------
// bbpe_front
// Input stage: takes items, writes loads to the point RAMs, queues evaluations.
// ----------------------------------------------------------------------------
module bbpe_front
    import bbpe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_op,
    input  logic [ADDR_W-1:0]      i_point_index,
    input  logic [COORD_WIDTH-1:0] i_load_x,
    input  logic [COORD_WIDTH-1:0] i_load_y,
    input  logic [COORD_WIDTH-1:0] i_load_z,
    input  logic [PARAM_W-1:0]     i_param_u,
    input  logic [PARAM_W-1:0]     i_param_v,
    input  logic                   i_back_idle,
    output logic                   o_we,
    output logic [ADDR_W-1:0]      o_waddr,
    output logic [COORD_WIDTH-1:0] o_wx,
    output logic [COORD_WIDTH-1:0] o_wy,
    output logic [COORD_WIDTH-1:0] o_wz,
    output logic                   o_cmd_valid,
    input  logic                   i_cmd_ready,
    output t_cmd                   o_cmd
);

    logic                   r_valid, n_valid;
    t_op                    r_op;
    logic [ADDR_W-1:0]      r_idx;
    logic [COORD_WIDTH-1:0] r_x, r_y, r_z;
    logic [PARAM_W-1:0]     r_u, r_v;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       take, q_push, q_pop;

    assign full = r_valid;
    assign take = push && !r_valid;

    always_comb begin
        n_valid = r_valid;
        q_push  = 1'b0;
        o_we    = 1'b0;
        if (r_valid) begin
            case (r_op)
                OP_LOAD: begin
                    // loads wait until every earlier evaluation has read the RAM
                    if (r_cnt == 2'd0 && i_back_idle) begin
                        o_we    = 1'b1;
                        n_valid = 1'b0;
                    end
                end
                OP_POINT, OP_DERIV: begin
                    if (r_cnt != 2'd2) begin
                        q_push  = 1'b1;
                        n_valid = 1'b0;
                    end
                end
                default: n_valid = 1'b0;
            endcase
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    assign q_pop = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt;
        case ({q_push, q_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 2'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            if (q_push) begin
                r_wp <= ~r_wp;
            end
            if (q_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op  <= t_op'(i_op);
            r_idx <= i_point_index;
            r_x   <= i_load_x;
            r_y   <= i_load_y;
            r_z   <= i_load_z;
            r_u   <= i_param_u;
            r_v   <= i_param_v;
        end
        if (q_push) begin
            r_q[r_wp] <= '{deriv: (r_op == OP_DERIV), u: r_u, v: r_v};
        end
    end

    assign o_waddr     = r_idx;
    assign o_wx        = r_x;
    assign o_wy        = r_y;
    assign o_wz        = r_z;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

@@ hw/rtl/bbpe_lane.sv @@
// ----------------------------------------------------------------------------
// bbpe_lane
// One coordinate datapath: cubic coefficients, Horner multiply-add, saturation.
// ----------------------------------------------------------------------------
module bbpe_lane
    import bbpe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  t_lane_ctl              i_ctl,
    input  logic [PARAM_W-1:0]     i_t,
    input  logic [COORD_WIDTH-1:0] i_pt,
    output logic [COORD_WIDTH-1:0] o_val,
    output logic                   o_ovf
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = COORD_WIDTH + 18;   // headroom for extrapolated t

    localparam logic signed [IW-1:0] SMAX = {{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [IW-1:0] SMIN = ~SMAX;

    logic        [CW-1:0]   r_pt  [4];
    logic signed [IW-1:0]   r_row [4];
    logic signed [IW-1:0]   r_acc;
    logic signed [IW-1:0]   r_k   [3];
    logic signed [IW-1:0]   r_ph;
    logic        [PARAM_W-1:0] r_pl;

    logic signed [IW-1:0]   a, b, c, d, c3, c2, c1, sum;
    logic signed [IW-17:0]  ah;
    logic signed [IW+1:0]   mh;
    logic        [32:0]     ml;

    always_comb begin
        if (i_ctl.pass_v) begin
            a = r_row[0];
            b = r_row[1];
            c = r_row[2];
            d = r_row[3];
        end else begin
            a = {{(IW-CW){r_pt[0][CW-1]}}, r_pt[0]};
            b = {{(IW-CW){r_pt[1][CW-1]}}, r_pt[1]};
            c = {{(IW-CW){r_pt[2][CW-1]}}, r_pt[2]};
            d = {{(IW-CW){r_pt[3][CW-1]}}, r_pt[3]};
        end
        c3 = d - a + (((b - c) <<< 1) + (b - c));
        c2 = ((a + c) <<< 1) + (a + c) - ((b <<< 2) + (b <<< 1));
        c1 = ((b - a) <<< 1) + (b - a);
    end

    // floor(acc * t / 2^16) split as high part times t plus low part times t
    assign ah  = r_acc[IW-1:FRAC_W];
    assign mh  = ah * $signed({1'b0, i_t});
    assign ml  = r_acc[FRAC_W-1:0] * i_t;
    assign sum = r_ph + {{(IW-PARAM_W){1'b0}}, r_pl} + r_k[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_pt[0] <= r_pt[1];
            r_pt[1] <= r_pt[2];
            r_pt[2] <= r_pt[3];
            r_pt[3] <= i_pt;
        end
        if (i_ctl.coef) begin
            if (i_ctl.deriv) begin
                r_acc  <= (c3 <<< 1) + c3;
                r_k[0] <= c2 <<< 1;
            end else begin
                r_acc  <= c3;
                r_k[0] <= c2;
            end
            r_k[1] <= c1;
            r_k[2] <= a;
        end
        if (i_ctl.mul) begin
            r_ph <= mh[IW-1:0];
            r_pl <= ml[32:FRAC_W];
        end
        if (i_ctl.add) begin
            r_acc  <= sum;
            r_k[0] <= r_k[1];
            r_k[1] <= r_k[2];
        end
        if (i_ctl.row_wr) begin
            r_row[i_ctl.row_sel] <= sum;
        end
    end

    always_comb begin
        o_ovf = 1'b1;
        if (r_acc > SMAX) begin
            o_val = SMAX[CW-1:0];
        end else if (r_acc < SMIN) begin
            o_val = SMIN[CW-1:0];
        end else begin
            o_val = r_acc[CW-1:0];
            o_ovf = 1'b0;
        end
    end

endmodule

@@ hw/rtl/bbpe_back.sv @@
// ----------------------------------------------------------------------------
// bbpe_back
// Evaluation sequencer: fetches rows, drives three lanes, holds the result.
// ----------------------------------------------------------------------------
module bbpe_back
    import bbpe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  t_cmd                   i_cmd,
    output logic                   o_idle,
    output logic [ADDR_W-1:0]      o_raddr,
    input  logic [COORD_WIDTH-1:0] i_rx,
    input  logic [COORD_WIDTH-1:0] i_ry,
    input  logic [COORD_WIDTH-1:0] i_rz,
    output logic                   empty,
    input  logic                   pop,
    output logic [COORD_WIDTH-1:0] o_out_x,
    output logic [COORD_WIDTH-1:0] o_out_y,
    output logic [COORD_WIDTH-1:0] o_out_z,
    output logic                   o_overflow
);

    t_state     r_state, n_state;
    t_cmd       r_cmd;
    logic [2:0] r_fk, n_fk;
    logic [1:0] r_row, n_row;
    logic       r_pass_v, n_pass_v;
    logic [1:0] r_left, n_left;
    t_lane_ctl  ctl;
    logic       load_cmd, load_out;

    logic                   r_ovalid;
    logic [COORD_WIDTH-1:0] r_ox, r_oy, r_oz;
    logic                   r_oovf;
    logic [COORD_WIDTH-1:0] vx, vy, vz;
    logic                   fx, fy, fz;

    always_comb begin
        n_state   = r_state;
        n_fk      = r_fk;
        n_row     = r_row;
        n_pass_v  = r_pass_v;
        n_left    = r_left;
        load_cmd  = 1'b0;
        load_out  = 1'b0;
        ctl       = '0;
        ctl.pass_v  = r_pass_v;
        ctl.deriv   = r_cmd.deriv;
        ctl.row_sel = r_row;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    load_cmd = 1'b1;
                    n_fk     = 3'd0;
                    n_row    = 2'd0;
                    n_pass_v = 1'b0;
                    n_state  = S_FETCH;
                end
            end
            S_FETCH: begin
                // the RAM registers its read data, so it arrives in the cycle after the address
                ctl.cap = (r_fk != 3'd0);
                if (r_fk == 3'd4) begin
                    n_state = S_COEF;
                end else begin
                    n_fk = r_fk + 3'd1;
                end
            end
            S_COEF: begin
                ctl.coef = 1'b1;
                n_left   = r_cmd.deriv ? 2'd2 : 2'd3;
                n_state  = S_MUL;
            end
            S_MUL: begin
                ctl.mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                ctl.add = 1'b1;
                n_left  = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    if (r_pass_v) begin
                        n_state = S_OUT;
                    end else begin
                        ctl.row_wr = 1'b1;
                        if (r_row == 2'd3) begin
                            n_pass_v = 1'b1;
                            n_state  = S_COEF;
                        end else begin
                            n_row   = r_row + 2'd1;
                            n_fk    = 3'd0;
                            n_state = S_FETCH;
                        end
                    end
                end else begin
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (!r_ovalid || pop) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_ovalid && !pop) || load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fk     <= n_fk;
        r_row    <= n_row;
        r_pass_v <= n_pass_v;
        r_left   <= n_left;
        if (load_cmd) begin
            r_cmd <= i_cmd;
        end
        if (load_out) begin
            r_ox   <= vx;
            r_oy   <= vy;
            r_oz   <= vz;
            r_oovf <= fx | fy | fz;
        end
    end

    logic [PARAM_W-1:0] t_sel;
    assign t_sel = r_pass_v ? r_cmd.v : r_cmd.u;

    bbpe_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .i_clk(i_clk), .i_ctl(ctl), .i_t(t_sel), .i_pt(i_rx), .o_val(vx), .o_ovf(fx)
    );
    bbpe_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .i_clk(i_clk), .i_ctl(ctl), .i_t(t_sel), .i_pt(i_ry), .o_val(vy), .o_ovf(fy)
    );
    bbpe_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .i_clk(i_clk), .i_ctl(ctl), .i_t(t_sel), .i_pt(i_rz), .o_val(vz), .o_ovf(fz)
    );

    assign o_cmd_ready = load_cmd;
    assign o_idle      = (r_state == S_IDLE);
    assign o_raddr     = {r_row, r_fk[1:0]};
    assign empty       = !r_ovalid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_overflow  = r_oovf;

endmodule

@@ hw/rtl/bicubic_bezier_patch_eval_core.sv @@
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_core
// Bicubic Bezier patch evaluator: point P(u,v) or mixed derivative d2P/dudv.
// ----------------------------------------------------------------------------
// A load waits in the front's input register and is written to the RAMs
// from there, later if an evaluation is queued or running. An evaluation
// runs four row passes, each of fetch, coefficient and Horner multiply-add
// steps, then one column pass, all on one multiply-add stage per coordinate.
// The back takes no new evaluation until its result is in the output register,
// which waits while an unpopped result is held; queued evaluations wait in
// the front meanwhile, loads wait for the back to go idle. Reset (synchronous,
// active low) empties the queues; RAMs keep their contents and must be loaded
// before use.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_core
    import bbpe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input side, queue style
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_op,
    input  logic [ADDR_W-1:0]      i_point_index,
    input  logic [COORD_WIDTH-1:0] i_load_x,
    input  logic [COORD_WIDTH-1:0] i_load_y,
    input  logic [COORD_WIDTH-1:0] i_load_z,
    input  logic [PARAM_W-1:0]     i_param_u,
    input  logic [PARAM_W-1:0]     i_param_v,
    // result side, queue style
    output logic                   empty,
    input  logic                   pop,
    output logic [COORD_WIDTH-1:0] o_out_x,
    output logic [COORD_WIDTH-1:0] o_out_y,
    output logic [COORD_WIDTH-1:0] o_out_z,
    output logic                   o_overflow
);

    // RAM write port, owned by the front
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [COORD_WIDTH-1:0] wx, wy, wz;
    // RAM read port, owned by the back
    logic [ADDR_W-1:0]      raddr;
    logic [COORD_WIDTH-1:0] rx, ry, rz;
    // command transfer between front and back
    logic                   cmd_valid, cmd_ready, back_idle;
    t_cmd                   cmd;

    bbpe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_point_index (i_point_index),
        .i_load_x      (i_load_x),
        .i_load_y      (i_load_y),
        .i_load_z      (i_load_z),
        .i_param_u     (i_param_u),
        .i_param_v     (i_param_v),
        .i_back_idle   (back_idle),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wx          (wx),
        .o_wy          (wy),
        .o_wz          (wz),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_ready   (cmd_ready),
        .o_cmd         (cmd)
    );

    // one RAM per coordinate, 16 control points in row-major order
    bbpe_ram #(.WIDTH(COORD_WIDTH), .DEPTH(NUM_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wx),
        .i_raddr(raddr), .o_rdata(rx)
    );
    bbpe_ram #(.WIDTH(COORD_WIDTH), .DEPTH(NUM_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wy),
        .i_raddr(raddr), .o_rdata(ry)
    );
    bbpe_ram #(.WIDTH(COORD_WIDTH), .DEPTH(NUM_POINTS)) u_ram_z (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wz),
        .i_raddr(raddr), .o_rdata(rz)
    );

    bbpe_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_idle      (back_idle),
        .o_raddr     (raddr),
        .i_rx        (rx),
        .i_ry        (ry),
        .i_rz        (rz),
        .empty       (empty),
        .pop         (pop),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_overflow  (o_overflow)
    );

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // a saturated result shows at least one coordinate at a rail
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_overflow) |-> (o_out_x == CMAX || o_out_x == CMIN ||
                                    o_out_y == CMAX || o_out_y == CMIN ||
                                    o_out_z == CMAX || o_out_z == CMIN))
        else $error("overflow flag without a saturated coordinate");

    // a RAM write never lands while the back is still reading points
    a_load_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (back_idle && !cmd_valid))
        else $error("control point written during an evaluation");

    // reset leaves no result behind
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule
